// ----- hdl/llbs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the laser line band sum profile block.
// Depends on nothing; every other file of the block imports it.
package llbs_pkg;

  // Column store geometry.
  localparam int MAX_COLUMNS   = 1024;
  localparam int COL_W         = $clog2(MAX_COLUMNS);
  localparam int CLR_W         = COL_W + 1;

  // Field widths.
  localparam int ROW_W         = 12;
  localparam int PIX_W         = 8;
  localparam int SUM_W         = 15;
  localparam int BAND_W        = 7;
  localparam int GAP_W         = 8;
  localparam int SPAN_W        = 9;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 12;

  // Band limits and saturation.
  localparam logic [BAND_W-1:0] MAX_BAND_ROWS = BAND_W'(64);
  localparam logic [SUM_W-1:0]  SUM_MAX       = {SUM_W{1'b1}};

  // Register reset values.
  localparam logic [BAND_W-1:0] BAND_ROWS_RST    = BAND_W'(10);
  localparam logic [GAP_W-1:0]  GAP_ROWS_RST     = GAP_W'(5);
  localparam logic [ROW_W-1:0]  IMAGE_HEIGHT_RST = ROW_W'(1024);

  // Output queue depth.
  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND_ROWS    = 2'd0,
    CFG_GAP_ROWS     = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_index_t;

  // Item kinds.
  typedef enum logic {
    REQ_LINE  = 1'b0,
    REQ_PIXEL = 1'b1
  } req_type_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_LINE = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  // One entry of the column memory.
  typedef struct packed {
    logic             active;
    logic [ROW_W-1:0] line_row;
    logic [SUM_W-1:0] acc;
  } col_entry_t;

  // One queued result item.
  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [SUM_W-1:0] band_sum;
    logic [1:0]       status;
  } result_t;

endpackage

// ----- hdl/llbs_in_if.sv -----
`timescale 1ns / 1ps
// Input channel of the band sum block: line items and raster pixels.
// Depends on llbs_pkg for the field widths.
interface llbs_in_if import llbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] pixel_row;
  logic [PIX_W-1:0] pixel_value;
  logic [ROW_W-1:0] line_row;
  logic             line_valid;

  modport source (output valid, req_type, column, pixel_row, pixel_value, line_row,
                  line_valid, input ready);
  modport sink   (input valid, req_type, column, pixel_row, pixel_value, line_row,
                  line_valid, output ready);
endinterface

// ----- hdl/llbs_out_if.sv -----
`timescale 1ns / 1ps
// Result channel of the band sum block: one profile value per column.
// Depends on llbs_pkg for the field widths.
interface llbs_out_if import llbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] out_column;
  logic [SUM_W-1:0] band_sum;
  logic [1:0]       status;

  modport source (output valid, out_column, band_sum, status, input ready);
  modport sink   (input valid, out_column, band_sum, status, output ready);
endinterface

// ----- hdl/llbs_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel of the band sum block.
// Depends on llbs_pkg for the index and data widths.
interface llbs_cfg_if import llbs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/laser_line_band_sum_profile_core.sv -----
`timescale 1ns / 1ps
// Results pass from stage one into the output queue. Throughput: one item per cycle while
// input is not held off, set by the single read-modify-write of the column memory. The
// three-entry output queue lets input continue while a result waits to be taken. Reset:
// registers take their reset values and a clearing pass zeroes all 1024 column memory
// entries; no item is accepted during the pass, configuration writes are.
module laser_line_band_sum_profile_core import llbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  llbs_in_if.sink     in_ch,
  llbs_out_if.source  out_ch,
  llbs_cfg_if.sink    cfg_ch
);

  // Configuration registers.
  logic [BAND_W-1:0] band_rows_r;
  logic [GAP_W-1:0]  gap_rows_r;
  logic [ROW_W-1:0]  image_height_r;

  // Column memory and its registered read data.
  col_entry_t mem [MAX_COLUMNS];
  col_entry_t rd_data_r;

  // Clearing pass counter; the top bit marks the pass as done.
  logic [CLR_W-1:0] clr_cnt_r;
  logic             clearing;

  // Stage one: the item whose entry is being read back.
  logic             s1_valid_r;
  logic             s1_req_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_prow_r;
  logic [PIX_W-1:0] s1_pval_r;
  logic [ROW_W-1:0] s1_lrow_r;
  logic             s1_lval_r;

  // Bypass of the last write, for an item on the same column right behind it.
  logic             byp_valid_r;
  logic [COL_W-1:0] byp_addr_r;
  col_entry_t       byp_data_r;

  // Output queue.
  result_t               fifo_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  logic       in_acc;
  logic       out_acc;
  col_entry_t ent;
  col_entry_t wr_data;
  logic       wr_en;
  logic       push;
  result_t    push_res;

  logic [BAND_W-1:0] b_eff;
  logic [SPAN_W-1:0] span;
  logic [ROW_W:0]    s_x, b_x, lrow_x, l_x, prow_x;
  logic [ROW_W:0]    r_row, up_lo, low_last;
  logic              in_range, in_up, in_low;
  logic [SUM_W:0]    acc_sum;
  logic [SUM_W-1:0]  acc_new;

  assign clearing = !clr_cnt_r[CLR_W-1];
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_ch.valid && out_ch.ready;

  // Input is held off during the clearing pass and when the queue could overflow.
  assign in_ch.ready = !clearing &&
                       ((FIFO_CNT_W+1)'(cnt_r) + (FIFO_CNT_W+1)'(s1_valid_r) <=
                        (FIFO_CNT_W+1)'(FIFO_DEPTH - 1));
  assign cfg_ch.ready = 1'b1;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_rows_r    <= BAND_ROWS_RST;
      gap_rows_r     <= GAP_ROWS_RST;
      image_height_r <= IMAGE_HEIGHT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_BAND_ROWS:    band_rows_r    <= cfg_ch.data[BAND_W-1:0];
        CFG_GAP_ROWS:     gap_rows_r     <= cfg_ch.data[GAP_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_ch.data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clearing) begin
      clr_cnt_r <= clr_cnt_r + CLR_W'(1);
    end
  end

  // Stage one control and payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r  <= in_ch.req_type;
      s1_col_r  <= in_ch.column;
      s1_prow_r <= in_ch.pixel_row;
      s1_pval_r <= in_ch.pixel_value;
      s1_lrow_r <= in_ch.line_row;
      s1_lval_r <= in_ch.line_valid;
    end
  end

  // Memory read port, addressed by the incoming item.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[in_ch.column];
  end

  // Memory write port: clearing pass or stage one write-back.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt_r[COL_W-1:0]] <= '0;
    end else if (wr_en) begin
      mem[s1_col_r] <= wr_data;
    end
  end

  // Bypass register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_valid_r <= 1'b0;
    end else begin
      byp_valid_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byp_addr_r <= s1_col_r;
      byp_data_r <= wr_data;
    end
  end

  // Band geometry from the current registers.
  always_comb begin
    if (band_rows_r == '0) begin
      b_eff = BAND_W'(1);
    end else if (band_rows_r > MAX_BAND_ROWS) begin
      b_eff = MAX_BAND_ROWS;
    end else begin
      b_eff = band_rows_r;
    end
    span = SPAN_W'(b_eff) + SPAN_W'(gap_rows_r);
    s_x  = (ROW_W+1)'(span);
    b_x  = (ROW_W+1)'(b_eff);
  end

  // Read-modify-write of the column entry.
  always_comb begin
    if (byp_valid_r && byp_addr_r == s1_col_r) begin
      ent = byp_data_r;
    end else begin
      ent = rd_data_r;
    end

    lrow_x   = (ROW_W+1)'(s1_lrow_r);
    in_range = ((ROW_W+1)'(image_height_r) > lrow_x + s_x) && (lrow_x > s_x);

    l_x      = (ROW_W+1)'(ent.line_row);
    prow_x   = (ROW_W+1)'(s1_prow_r);
    r_row    = prow_x + s_x;
    up_lo    = l_x + b_x;
    low_last = l_x + s_x;
    in_up    = (r_row >= l_x) && (r_row < up_lo);
    in_low   = (prow_x + b_x > low_last) && (prow_x <= low_last);

    acc_sum = (SUM_W+1)'(ent.acc) + (SUM_W+1)'(s1_pval_r);
    if (!(in_up || in_low)) begin
      acc_new = ent.acc;
    end else if (acc_sum > (SUM_W+1)'(SUM_MAX)) begin
      acc_new = SUM_MAX;
    end else begin
      acc_new = acc_sum[SUM_W-1:0];
    end

    wr_en           = 1'b0;
    wr_data         = ent;
    push            = 1'b0;
    push_res.column = s1_col_r;
    push_res.band_sum = '0;
    push_res.status = ST_OK;

    if (s1_valid_r) begin
      if (s1_req_r == REQ_LINE) begin
        // A line item restarts the column.
        wr_en            = 1'b1;
        wr_data.line_row = s1_lrow_r;
        wr_data.acc      = '0;
        wr_data.active   = s1_lval_r && in_range;
        if (!s1_lval_r) begin
          push            = 1'b1;
          push_res.status = ST_NO_LINE;
        end else if (!in_range) begin
          push            = 1'b1;
          push_res.status = ST_OUTSIDE;
        end
      end else if (ent.active) begin
        // A pixel of an armed column; the last row of the lower band closes it.
        wr_en       = 1'b1;
        wr_data.acc = acc_new;
        if (prow_x == low_last) begin
          wr_data.active    = 1'b0;
          push              = 1'b1;
          push_res.band_sum = acc_new;
        end
      end
    end
  end

  // Output queue pointers and count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + FIFO_PTR_W'(1);
    end
    if (out_acc) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + FIFO_PTR_W'(1);
    end
    if (push && !out_acc) begin
      cnt_nxt = cnt_r + FIFO_CNT_W'(1);
    end else if (!push && out_acc) begin
      cnt_nxt = cnt_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= push_res;
    end
  end

  // Result channel driven from the queue head.
  assign out_ch.valid      = (cnt_r != '0);
  assign out_ch.out_column = fifo_r[rd_ptr_r].column;
  assign out_ch.band_sum   = fifo_r[rd_ptr_r].band_sum;
  assign out_ch.status     = fifo_r[rd_ptr_r].status;

  // The queue never holds more items than it has entries.
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("output queue overflow");

  // An item never reaches stage one while the clearing pass runs.
  a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !s1_valid_r)
    else $error("item in flight during clearing pass");

  // A result that is not ok carries a zero sum.
  a_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_OK) |-> out_ch.band_sum == '0)
    else $error("nonzero sum with error status");

  // A push never meets a full queue.
  a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != FIFO_CNT_W'(FIFO_DEPTH) || out_acc))
    else $error("result pushed into full queue");

  // The bypass only ever holds the write of the item just before.
  a_bypass_src: assert property (@(posedge clk) disable iff (!rst_n)
    byp_valid_r |-> $past(s1_valid_r))
    else $error("bypass without a preceding write-back");

endmodule

// ----- sim/laser_line_band_sum_profile_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of laser_line_band_sum_profile_core: line items and raster
// pixels go in, and every column profile that comes out is compared with a prediction.
// Depends on llbs_pkg, the three channel interfaces and the core itself.
module laser_line_band_sum_profile_core_tb;
  import llbs_pkg::*;

  localparam int     ROW_LAST      = (1 << ROW_W) - 1;
  localparam int     COL_LAST      = MAX_COLUMNS - 1;
  localparam int     RANDOM_ITEMS  = 900;
  localparam int     SETTLE_CYCLES = 4;
  localparam int     DRAIN_LIMIT   = 4000;
  localparam longint WATCHDOG_NS   = 5_000_000;

  // One input item as the sender sees it.
  typedef struct {
    req_type_t        kind;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] pixel_row;
    logic [PIX_W-1:0] pixel_value;
    logic [ROW_W-1:0] line_row;
    logic             line_valid;
  } band_item_t;

  logic clk;
  logic rst_n;

  llbs_in_if  in_bus ();
  llbs_out_if out_bus ();
  llbs_cfg_if cfg_bus ();

  laser_line_band_sum_profile_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // Shadow copy of the registers and the column memory.
  logic [BAND_W-1:0] band_rows_q = BAND_ROWS_RST;
  logic [GAP_W-1:0]  gap_rows_q  = GAP_ROWS_RST;
  logic [ROW_W-1:0]  height_q    = IMAGE_HEIGHT_RST;
  logic [ROW_W-1:0]  line_row_mem [MAX_COLUMNS];
  logic [SUM_W-1:0]  band_sum_mem [MAX_COLUMNS];
  bit                column_armed [MAX_COLUMNS];
  result_t           pending_profiles [$];

  int unsigned error_count  = 0;
  int unsigned useful_items = 0;
  int unsigned hold_request = 0;
  bit          in_idle_en   = 1'b1;
  bit          out_idle_en  = 1'b1;

  // Columns and line rows of the frame being sent.
  int frame_cols [$];
  int frame_rows [$];

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #(WATCHDOG_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int unsigned draw_pause(input bit enabled);
    return enabled ? $urandom_range(0, 19) : 0;
  endfunction

  // Band height as the block applies it: zero counts as one, large values are capped.
  function automatic int band_rows_used();
    if (band_rows_q == '0) return 1;
    if (band_rows_q > MAX_BAND_ROWS) return int'(MAX_BAND_ROWS);
    return int'(band_rows_q);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want, input int col);
    if (got !== want)
      report_mismatch($sformatf("column %0d %s: got %0d, expected %0d", col, name, got, want));
  endtask

  // Prediction of the profile that one accepted item causes, if any.
  task automatic predict_band_sum(input band_item_t it);
    int unsigned b, s, l, low_last, acc;
    bit          hit;
    result_t     r;
    b          = band_rows_used();
    s          = b + gap_rows_q;
    r.column   = it.column;
    r.band_sum = '0;
    r.status   = ST_OK;
    if (it.kind == REQ_LINE) begin
      line_row_mem[it.column] = it.line_row;
      band_sum_mem[it.column] = '0;
      column_armed[it.column] = 1'b0;
      if (!it.line_valid) begin
        r.status = ST_NO_LINE;
        pending_profiles.push_back(r);
      end else if (!(height_q > it.line_row + s && it.line_row > s)) begin
        r.status = ST_OUTSIDE;
        pending_profiles.push_back(r);
      end else begin
        column_armed[it.column] = 1'b1;
      end
    end else if (column_armed[it.column]) begin
      l        = line_row_mem[it.column];
      low_last = l + s;
      hit = (it.pixel_row + s >= l && it.pixel_row + s < l + b) ||
            (it.pixel_row + b > low_last && it.pixel_row <= low_last);
      if (hit) begin
        acc = band_sum_mem[it.column] + it.pixel_value;
        if (acc > SUM_MAX) acc = SUM_MAX;
        band_sum_mem[it.column] = SUM_W'(acc);
      end
      // The last row of the lower band closes the column.
      if (it.pixel_row == low_last) begin
        column_armed[it.column] = 1'b0;
        r.band_sum = band_sum_mem[it.column];
        pending_profiles.push_back(r);
      end
    end
  endtask

  // Sends one item; called just after a rising edge, returns at the accepting edge.
  // Valid stays high afterwards so that back-to-back items need no second assignment.
  task automatic send_item(input band_item_t it);
    int unsigned pause;
    pause = draw_pause(in_idle_en);
    if (pause != 0) begin
      in_bus.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.req_type    <= it.kind;
    in_bus.column      <= it.column;
    in_bus.pixel_row   <= it.pixel_row;
    in_bus.pixel_value <= it.pixel_value;
    in_bus.line_row    <= it.line_row;
    in_bus.line_valid  <= it.line_valid;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    predict_band_sum(it);
  endtask

  // Unused fields carry random values; the block must ignore them.
  task automatic send_line(input int col, input int row, input bit found);
    band_item_t it;
    it.kind        = REQ_LINE;
    it.column      = COL_W'(col);
    it.line_row    = ROW_W'(row);
    it.line_valid  = found;
    it.pixel_row   = ROW_W'($urandom_range(0, ROW_LAST));
    it.pixel_value = PIX_W'($urandom_range(0, 255));
    send_item(it);
  endtask

  task automatic send_pixel(input int col, input int row, input int value);
    band_item_t it;
    it.kind        = REQ_PIXEL;
    it.column      = COL_W'(col);
    it.pixel_row   = ROW_W'(row);
    it.pixel_value = PIX_W'(value);
    it.line_row    = ROW_W'($urandom_range(0, ROW_LAST));
    it.line_valid  = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  // A stray item with every field random.
  task automatic send_noise();
    band_item_t it;
    it.kind        = req_type_t'($urandom_range(0, 1));
    it.column      = COL_W'($urandom_range(0, COL_LAST));
    it.pixel_row   = ROW_W'($urandom_range(0, ROW_LAST));
    it.pixel_value = PIX_W'($urandom_range(0, 255));
    it.line_row    = ROW_W'($urandom_range(0, ROW_LAST));
    it.line_valid  = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  // Writes one register; called just after a rising edge, drops valid after acceptance.
  task automatic cfg_write(input cfg_index_t idx, input int unsigned value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    case (idx)
      CFG_BAND_ROWS:    band_rows_q = BAND_W'(value);
      CFG_GAP_ROWS:     gap_rows_q  = GAP_W'(value);
      CFG_IMAGE_HEIGHT: height_q    = ROW_W'(value);
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned band, input int unsigned gap,
                           input int unsigned height);
    cfg_write(CFG_BAND_ROWS, band);
    cfg_write(CFG_GAP_ROWS, gap);
    cfg_write(CFG_IMAGE_HEIGHT, height);
  endtask

  // Stops offering items and waits until every expected profile has come out.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (pending_profiles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Line row for a new line item: mostly one that arms the column, some at the
  // edges of the range test, some anywhere.
  function automatic int pick_line_row();
    int s, h, row;
    s = band_rows_used() + int'(gap_rows_q);
    h = int'(height_q);
    case ($urandom_range(0, 9))
      0: row = $urandom_range(0, ROW_LAST);
      1: begin
        case ($urandom_range(0, 3))
          0:       row = s;
          1:       row = s + 1;
          2:       row = h - s - 1;
          default: row = h - s;
        endcase
      end
      default: begin
        if (h > 2 * s + 1) row = $urandom_range(s + 1, h - s - 1);
        else row = $urandom_range(0, ROW_LAST);
      end
    endcase
    if (row < 0) row = 0;
    if (row > ROW_LAST) row = ROW_LAST;
    return row;
  endfunction

  // Raster pixels of the frame's columns, row by row, placed by the current registers.
  // Band rows always go out; rows near the bands go out now and then as noise.
  // A truncated raster stops before the last lower band row of the lowest line.
  task automatic send_raster(input bit truncate);
    int b, s, lo, hi, d;
    bit in_band;
    b  = band_rows_used();
    s  = b + int'(gap_rows_q);
    lo = ROW_LAST;
    hi = 0;
    foreach (frame_rows[i]) begin
      if (frame_rows[i] - s - 3 < lo) lo = frame_rows[i] - s - 3;
      if (frame_rows[i] + s + 3 > hi) hi = frame_rows[i] + s + 3;
    end
    if (lo < 0) lo = 0;
    if (hi > ROW_LAST) hi = ROW_LAST;
    if (truncate) hi = hi - 4 - int'($urandom_range(0, s));
    for (int r = lo; r <= hi; r++) begin
      foreach (frame_cols[i]) begin
        d       = r - frame_rows[i];
        in_band = (d >= -s && d < -s + b) || (d > s - b && d <= s);
        if (in_band) begin
          send_pixel(frame_cols[i], r, $urandom_range(0, 255));
          useful_items++;
          if ($urandom_range(0, 49) == 0) send_noise();
        end else if (d >= -s - 3 && d <= s + 3 && $urandom_range(0, 7) == 0) begin
          send_pixel(frame_cols[i], r, $urandom_range(0, 255));
        end
      end
    end
  endtask

  // A frame: line items for a few random columns, then their raster.
  task automatic run_frame(input int n_cols);
    int col, row;
    frame_cols.delete();
    frame_rows.delete();
    repeat (n_cols) begin
      col = $urandom_range(0, COL_LAST);
      row = pick_line_row();
      send_line(col, row, $urandom_range(0, 9) != 0);
      useful_items++;
      frame_cols.push_back(col);
      frame_rows.push_back(row);
    end
    send_raster($urandom_range(0, 5) == 0);
  endtask

  // Reset register values: bands, gap and line pixels, no line, range test edges,
  // repeated line item, pixels of disarmed and never armed columns.
  task automatic test_directed_cases();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    send_line(0, 100, 1'b1);
    send_pixel(0, 85, 255);
    send_pixel(0, 94, 0);
    send_pixel(0, 95, 200);
    send_pixel(0, 100, 17);
    send_pixel(0, 84, 255);
    send_pixel(0, 106, 1);
    send_pixel(0, ROW_LAST, 255);
    send_pixel(0, 115, 255);
    send_pixel(0, 115, 255);
    send_line(COL_LAST, ROW_LAST, 1'b0);
    send_line(3, 100, 1'b0);
    send_line(512, 15, 1'b1);
    send_line(513, 16, 1'b1);
    send_line(513, 1008, 1'b1);
    send_pixel(513, 1023, 9);
    send_line(514, 1009, 1'b1);
    send_pixel(700, 0, 255);
    wait_idle();
  endtask

  // Widest bands and repeated full-scale pixels drive the sum into saturation.
  task automatic test_sum_saturation();
    configure(64, 0, ROW_LAST);
    send_line(5, 200, 1'b1);
    repeat (130) send_pixel(5, 150, 255);
    send_pixel(5, 264, 255);
    wait_idle();
  endtask

  // Columns armed under one setting, then rastered after the gap and height change:
  // the range test stays as it was, the band placement follows the new gap.
  task automatic test_config_mid_frame();
    configure(4, 2, 1000);
    frame_cols.delete();
    frame_rows.delete();
    send_line(10, 100, 1'b1);
    send_line(11, 200, 1'b1);
    frame_cols.push_back(10);
    frame_rows.push_back(100);
    frame_cols.push_back(11);
    frame_rows.push_back(200);
    wait_idle();
    cfg_write(CFG_GAP_ROWS, 6);
    cfg_write(CFG_IMAGE_HEIGHT, 150);
    send_raster(1'b0);
    wait_idle();
  endtask

  // The receiver holds off while no-line items keep coming, so the output queue fills.
  task automatic test_output_stall();
    in_idle_en   = 1'b0;
    out_idle_en  = 1'b0;
    hold_request = 150;
    repeat (24) send_line($urandom_range(0, COL_LAST), $urandom_range(0, ROW_LAST), 1'b0);
    wait_idle();
  endtask

  // Phases of random frames, each under its own register setting.
  task automatic test_random_frames();
    int unsigned phase, mode, phase_start, budget;
    phase        = 0;
    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) begin
      mode = phase % 6;
      wait_idle();
      case (mode)
        0: configure(1, 0, ROW_LAST);
        1: configure(64, 255, ROW_LAST);
        2: configure(0, $urandom_range(0, 7), 1);
        3: configure(127, 0, $urandom_range(200, 600));
        default: configure($urandom_range(1, 8), $urandom_range(0, 15),
                           $urandom_range(40, ROW_LAST));
      endcase
      in_idle_en  = $urandom_range(0, 2) != 0;
      out_idle_en = $urandom_range(0, 2) != 0;
      phase_start = useful_items;
      budget      = (mode == 2) ? 40 : 110;
      while (useful_items - phase_start < budget && useful_items < RANDOM_ITEMS) begin
        if (mode == 1 || mode == 3) run_frame(1);
        else run_frame($urandom_range(1, 4));
      end
      phase++;
    end
  endtask

  // Result receiver: a random wait before each item, plus a long hold on request.
  initial begin : result_receiver
    int unsigned wait_left, hold_left;
    wait_left     = 0;
    hold_left     = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) wait_left = draw_pause(out_idle_en);
      else if (wait_left != 0) wait_left--;
      if (hold_left != 0) hold_left--;
      out_bus.ready <= (wait_left == 0) && (hold_left == 0);
    end
  end

  // Each accepted result is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_profiles.size() == 0) begin
        report_mismatch($sformatf("unexpected result: column %0d sum %0d status %0d",
                                  out_bus.out_column, out_bus.band_sum, out_bus.status));
      end else begin
        want = pending_profiles.pop_front();
        check_field("out_column", out_bus.out_column, want.column, want.column);
        check_field("band_sum", out_bus.band_sum, want.band_sum, want.column);
        check_field("status", out_bus.status, want.status, want.column);
      end
    end
  end

  // Reset, the tests in turn, then the drain and the verdict.
  initial begin : test_sequence
    int n;
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.req_type    <= REQ_LINE;
    in_bus.column      <= '0;
    in_bus.pixel_row   <= '0;
    in_bus.pixel_value <= '0;
    in_bus.line_row    <= '0;
    in_bus.line_valid  <= 1'b0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= CFG_BAND_ROWS;
    cfg_bus.data       <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_sum_saturation();
    test_config_mid_frame();
    test_output_stall();
    test_random_frames();

    in_bus.valid <= 1'b0;
    for (n = 0; n < DRAIN_LIMIT && pending_profiles.size() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_profiles.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_profiles.size()));
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
